/* hw/rtl/rgbhsv_pkg.sv */
`default_nettype none

package rgbhsv_pkg;

    // Default channel width of a pixel
    localparam int CHANNEL_BITS_DEF = 8;

    // Divider: quotient bits (one bit per pipeline stage) and numerator growth
    localparam int QUO_W     = 11;
    localparam int NUM_EXTRA = 11;

    // Divider lanes
    localparam int NUM_LANES = 3;
    localparam int LANE_HUE  = 0;
    localparam int LANE_SAT  = 1;
    localparam int LANE_VAL  = 2;

    // Scale factors, doubled for round to nearest
    localparam int HUE_SCALE = 1200;
    localparam int PCT_SCALE = 2000;

    // Result widths
    localparam int HUE_W     = 12;
    localparam int SAT_W     = 10;
    localparam int VAL_W     = 10;
    localparam int HUE_SUM_W = 13;

    // Sector base in tenths of a degree, less the 60 degree bias of the divider
    localparam logic [HUE_SUM_W-1:0] HUE_BASE_RED   = 13'd3000;
    localparam logic [HUE_SUM_W-1:0] HUE_BASE_GREEN = 13'd600;
    localparam logic [HUE_SUM_W-1:0] HUE_BASE_BLUE  = 13'd1800;
    localparam logic [HUE_SUM_W-1:0] HUE_WRAP       = 13'd3600;

    localparam logic [SAT_W-1:0] PCT_MAX = 10'd1000;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Control that travels beside the divider lanes
    typedef struct packed {
        sector_t sector;
        logic    grey;
        logic    black;
    } side_t;

endpackage

`default_nettype wire

/* hw/rtl/rgbhsv_pixel_if.sv */
`default_nettype none

interface rgbhsv_pixel_if #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] red;

    modport source (output valid, blue, green, red, input ready);
    modport sink   (input valid, blue, green, red, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rgbhsv_hsv_if.sv */
`default_nettype none

interface rgbhsv_hsv_if;
    logic                           valid;
    logic                           ready;
    logic [rgbhsv_pkg::HUE_W-1:0]   hue_tenths;
    logic [rgbhsv_pkg::SAT_W-1:0]   sat_tenths;
    logic [rgbhsv_pkg::VAL_W-1:0]   value_tenths;

    modport source (output valid, hue_tenths, sat_tenths, value_tenths, input ready);
    modport sink   (input valid, hue_tenths, sat_tenths, value_tenths, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rgbhsv_front.sv */
`default_nettype none

module rgbhsv_front #(
    parameter  int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF,
    localparam int DEN_W        = CHANNEL_BITS + 1,
    localparam int NUM_W        = CHANNEL_BITS + 1 + rgbhsv_pkg::NUM_EXTRA
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    rgbhsv_pixel_if.sink          pixel,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output logic [NUM_W-1:0]      dn_num [rgbhsv_pkg::NUM_LANES],
    output logic [DEN_W-1:0]      dn_den [rgbhsv_pkg::NUM_LANES],
    output rgbhsv_pkg::side_t     dn_side
);

    localparam logic [CHANNEL_BITS-1:0] FULL = '1;

    logic s1_ready;
    logic s2_ready;
    logic s1_valid_reg;
    logic s2_valid_reg;

    logic [CHANNEL_BITS-1:0] mx_next;
    logic [CHANNEL_BITS-1:0] mn_next;
    logic [CHANNEL_BITS-1:0] d_next;
    logic [CHANNEL_BITS:0]   m_next;
    rgbhsv_pkg::sector_t     sector_next;

    logic [CHANNEL_BITS-1:0] mx_reg;
    logic [CHANNEL_BITS-1:0] d_reg;
    logic [CHANNEL_BITS:0]   m_reg;
    rgbhsv_pkg::sector_t     sector_reg;

    logic [NUM_W-1:0]        num_next [rgbhsv_pkg::NUM_LANES];
    logic [DEN_W-1:0]        den_next [rgbhsv_pkg::NUM_LANES];
    rgbhsv_pkg::side_t       side_next;

    logic [NUM_W-1:0]        num_reg [rgbhsv_pkg::NUM_LANES];
    logic [DEN_W-1:0]        den_reg [rgbhsv_pkg::NUM_LANES];
    rgbhsv_pkg::side_t       side_reg;

    // Advance a stage when it is empty or the next one takes its beat
    assign s2_ready    = !s2_valid_reg || dn_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel.ready = s1_ready;

    // Stage 1: largest, smallest, spread and hue sector
    always_comb
    begin
        mx_next = pixel.red;
        mn_next = pixel.red;
        if (pixel.green > mx_next)
        begin
            mx_next = pixel.green;
        end
        if (pixel.blue > mx_next)
        begin
            mx_next = pixel.blue;
        end
        if (pixel.green < mn_next)
        begin
            mn_next = pixel.green;
        end
        if (pixel.blue < mn_next)
        begin
            mn_next = pixel.blue;
        end
        d_next = mx_next - mn_next;

        // Biased numerator m = n + d, always within 0..2d
        if (pixel.red == mx_next)
        begin
            sector_next = rgbhsv_pkg::SECT_RED;
            m_next = ({1'b0, pixel.green} + {1'b0, d_next}) - {1'b0, pixel.blue};
        end
        else if (pixel.green == mx_next)
        begin
            sector_next = rgbhsv_pkg::SECT_GREEN;
            m_next = ({1'b0, pixel.blue} + {1'b0, d_next}) - {1'b0, pixel.red};
        end
        else
        begin
            sector_next = rgbhsv_pkg::SECT_BLUE;
            m_next = ({1'b0, pixel.red} + {1'b0, d_next}) - {1'b0, pixel.green};
        end
    end

    // Stage 2: numerators and denominators of the three rounded quotients
    always_comb
    begin
        num_next[rgbhsv_pkg::LANE_HUE] = NUM_W'(m_reg) * NUM_W'(rgbhsv_pkg::HUE_SCALE)
                                       + NUM_W'(d_reg);
        den_next[rgbhsv_pkg::LANE_HUE] = {d_reg, 1'b0};
        num_next[rgbhsv_pkg::LANE_SAT] = NUM_W'(d_reg) * NUM_W'(rgbhsv_pkg::PCT_SCALE)
                                       + NUM_W'(mx_reg);
        den_next[rgbhsv_pkg::LANE_SAT] = {mx_reg, 1'b0};
        num_next[rgbhsv_pkg::LANE_VAL] = NUM_W'(mx_reg) * NUM_W'(rgbhsv_pkg::PCT_SCALE)
                                       + NUM_W'(FULL);
        den_next[rgbhsv_pkg::LANE_VAL] = {FULL, 1'b0};
        side_next.sector = sector_reg;
        side_next.grey   = (d_reg == '0);
        side_next.black  = (mx_reg == '0);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pixel.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: load on a moving beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (pixel.valid && s1_ready)
        begin
            mx_reg     <= mx_next;
            d_reg      <= d_next;
            m_reg      <= m_next;
            sector_reg <= sector_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign dn_num   = num_reg;
    assign dn_den   = den_reg;
    assign dn_side  = side_reg;

endmodule

`default_nettype wire

/* hw/rtl/rgbhsv_div.sv */
`default_nettype none

module rgbhsv_div #(
    parameter  int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF,
    localparam int DEN_W        = CHANNEL_BITS + 1,
    localparam int NUM_W        = CHANNEL_BITS + 1 + rgbhsv_pkg::NUM_EXTRA,
    localparam int QW           = rgbhsv_pkg::QUO_W
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire logic [NUM_W-1:0]  up_num [rgbhsv_pkg::NUM_LANES],
    input  wire logic [DEN_W-1:0]  up_den [rgbhsv_pkg::NUM_LANES],
    input  wire rgbhsv_pkg::side_t up_side,
    output logic                   dn_valid,
    input  wire logic              dn_ready,
    output logic [QW-1:0]          dn_quo [rgbhsv_pkg::NUM_LANES],
    output rgbhsv_pkg::side_t      dn_side
);

    // Restoring division, one quotient bit per stage, three lanes in step
    logic              stage_ready [QW+1];
    logic              valid_reg   [QW];
    rgbhsv_pkg::side_t side_reg    [QW];

    logic [DEN_W-1:0]  rem_reg [QW][rgbhsv_pkg::NUM_LANES];
    logic [QW-1:0]     low_reg [QW][rgbhsv_pkg::NUM_LANES];
    logic [DEN_W-1:0]  den_reg [QW][rgbhsv_pkg::NUM_LANES];
    logic [QW-1:0]     quo_reg [QW][rgbhsv_pkg::NUM_LANES];

    logic              src_valid [QW];
    rgbhsv_pkg::side_t src_side  [QW];
    logic [DEN_W-1:0]  src_rem   [QW][rgbhsv_pkg::NUM_LANES];
    logic [QW-1:0]     src_low   [QW][rgbhsv_pkg::NUM_LANES];
    logic [DEN_W-1:0]  src_den   [QW][rgbhsv_pkg::NUM_LANES];
    logic [QW-1:0]     src_quo   [QW][rgbhsv_pkg::NUM_LANES];

    logic [DEN_W-1:0]  rem_next  [QW][rgbhsv_pkg::NUM_LANES];
    logic [QW-1:0]     low_next  [QW][rgbhsv_pkg::NUM_LANES];
    logic [QW-1:0]     quo_next  [QW][rgbhsv_pkg::NUM_LANES];

    assign stage_ready[QW] = dn_ready;
    assign up_ready        = stage_ready[0];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        // Advance when empty or when the next stage takes the beat
        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];

        if (k == 0)
        begin : g_first
            assign src_valid[k] = up_valid;
            assign src_side[k]  = up_side;
        end
        else
        begin : g_rest
            assign src_valid[k] = valid_reg[k-1];
            assign src_side[k]  = side_reg[k-1];
        end

        for (genvar l = 0; l < rgbhsv_pkg::NUM_LANES; l++)
        begin : g_lane
            logic [DEN_W:0] trial;
            logic           fits;

            if (k == 0)
            begin : g_load
                // Quotient fits QW bits, so the top slice is below the divisor
                assign src_rem[k][l] = up_num[l][NUM_W-1:QW];
                assign src_low[k][l] = up_num[l][QW-1:0];
                assign src_den[k][l] = up_den[l];
                assign src_quo[k][l] = '0;
            end
            else
            begin : g_chain
                assign src_rem[k][l] = rem_reg[k-1][l];
                assign src_low[k][l] = low_reg[k-1][l];
                assign src_den[k][l] = den_reg[k-1][l];
                assign src_quo[k][l] = quo_reg[k-1][l];
            end

            // Shift in the next numerator bit and try one subtraction
            assign trial = {src_rem[k][l], src_low[k][l][QW-1]};
            assign fits  = (trial >= {1'b0, src_den[k][l]});
            assign rem_next[k][l] = fits ? DEN_W'(trial - {1'b0, src_den[k][l]})
                                         : DEN_W'(trial);
            assign low_next[k][l] = {src_low[k][l][QW-2:0], 1'b0};
            assign quo_next[k][l] = {src_quo[k][l][QW-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stage_ready[k])
            begin
                valid_reg[k] <= src_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (src_valid[k] && stage_ready[k])
            begin
                side_reg[k] <= src_side[k];
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                den_reg[k]  <= src_den[k];
                quo_reg[k]  <= quo_next[k];
            end
        end
    end

    assign dn_valid = valid_reg[QW-1];
    assign dn_quo   = quo_reg[QW-1];
    assign dn_side  = side_reg[QW-1];

`ifndef ASSERT_OFF
    // An accepted beat lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=> valid_reg[0])
        else $error("rgbhsv_div: accepted beat missing from first stage");

    // A stalled last stage keeps its hue quotient
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QW-1] && !dn_ready |=>
            valid_reg[QW-1] && $stable(quo_reg[QW-1][rgbhsv_pkg::LANE_HUE]))
        else $error("rgbhsv_div: stalled quotient changed");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rgbhsv_back.sv */
`default_nettype none

module rgbhsv_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic [rgbhsv_pkg::QUO_W-1:0]  up_quo [rgbhsv_pkg::NUM_LANES],
    input  wire rgbhsv_pkg::side_t             up_side,
    rgbhsv_hsv_if.source                       hsv
);

    logic [rgbhsv_pkg::HUE_SUM_W-1:0] base;
    logic [rgbhsv_pkg::HUE_SUM_W-1:0] hue_sum;
    logic [rgbhsv_pkg::HUE_SUM_W-1:0] hue_wrapped;

    logic [rgbhsv_pkg::HUE_W-1:0] hue_next;
    logic [rgbhsv_pkg::SAT_W-1:0] sat_next;
    logic [rgbhsv_pkg::VAL_W-1:0] val_next;

    logic                         valid_reg;
    logic [rgbhsv_pkg::HUE_W-1:0] hue_reg;
    logic [rgbhsv_pkg::SAT_W-1:0] sat_reg;
    logic [rgbhsv_pkg::VAL_W-1:0] val_reg;

    // Output register frees up whenever the receiver takes the beat
    assign up_ready = !valid_reg || hsv.ready;

    // Add the sector base, wrap at a full turn, apply grey and black cases
    always_comb
    begin
        case (up_side.sector)
            rgbhsv_pkg::SECT_RED:   base = rgbhsv_pkg::HUE_BASE_RED;
            rgbhsv_pkg::SECT_GREEN: base = rgbhsv_pkg::HUE_BASE_GREEN;
            rgbhsv_pkg::SECT_BLUE:  base = rgbhsv_pkg::HUE_BASE_BLUE;
            default:                base = rgbhsv_pkg::HUE_BASE_RED;
        endcase
        hue_sum = rgbhsv_pkg::HUE_SUM_W'(up_quo[rgbhsv_pkg::LANE_HUE]) + base;
        hue_wrapped = (hue_sum >= rgbhsv_pkg::HUE_WRAP) ? hue_sum - rgbhsv_pkg::HUE_WRAP
                                                         : hue_sum;
        hue_next = up_side.grey ? '0 : hue_wrapped[rgbhsv_pkg::HUE_W-1:0];
        sat_next = up_side.black ? '0
                                 : up_quo[rgbhsv_pkg::LANE_SAT][rgbhsv_pkg::SAT_W-1:0];
        val_next = up_quo[rgbhsv_pkg::LANE_VAL][rgbhsv_pkg::VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= val_next;
        end
    end

    assign hsv.valid        = valid_reg;
    assign hsv.hue_tenths   = hue_reg;
    assign hsv.sat_tenths   = sat_reg;
    assign hsv.value_tenths = val_reg;

`ifndef ASSERT_OFF
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> hue_reg < rgbhsv_pkg::HUE_WRAP[rgbhsv_pkg::HUE_W-1:0])
        else $error("rgbhsv_back: hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> sat_reg <= rgbhsv_pkg::PCT_MAX)
        else $error("rgbhsv_back: saturation out of range");

    a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> val_reg <= rgbhsv_pkg::PCT_MAX)
        else $error("rgbhsv_back: value out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsv_converter.sv */
// RGB to HSV converter, fully pipelined.
//
// Channels: pixel (sink) carries blue, green, red of CHANNEL_BITS each;
// hsv (source) carries hue_tenths (0..3599), sat_tenths and value_tenths
// (0..1000). Both use valid/ready; a beat moves when both are high.
// Throughput: one pixel per clock, sustained while hsv.ready stays high.
// Stages from an accepted pixel beat to its result on hsv:
// two front stages (extremes, then numerators), eleven divider stages
// (restoring division, one quotient bit per stage, hue, saturation and
// value in parallel lanes) and the output register.
// Each stage advances when empty or when the stage after it moves, so
// bubbles close up while the receiver stalls; pixel.ready drops only once
// every stage holds a result. Nothing is dropped or repeated on a stall.
// Reset clears all valid bits, so the block is ready for a pixel as
// soon as reset is released.
`default_nettype none

module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rgbhsv_pixel_if.sink pixel,
    rgbhsv_hsv_if.source hsv
);

    localparam int DEN_W = CHANNEL_BITS + 1;
    localparam int NUM_W = CHANNEL_BITS + 1 + rgbhsv_pkg::NUM_EXTRA;

    logic              fd_valid;
    logic              fd_ready;
    logic [NUM_W-1:0]  fd_num [rgbhsv_pkg::NUM_LANES];
    logic [DEN_W-1:0]  fd_den [rgbhsv_pkg::NUM_LANES];
    rgbhsv_pkg::side_t fd_side;

    logic                         db_valid;
    logic                         db_ready;
    logic [rgbhsv_pkg::QUO_W-1:0] db_quo [rgbhsv_pkg::NUM_LANES];
    rgbhsv_pkg::side_t            db_side;

    rgbhsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .dn_valid (fd_valid),
        .dn_ready (fd_ready),
        .dn_num   (fd_num),
        .dn_den   (fd_den),
        .dn_side  (fd_side)
    );

    rgbhsv_div #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fd_valid),
        .up_ready (fd_ready),
        .up_num   (fd_num),
        .up_den   (fd_den),
        .up_side  (fd_side),
        .dn_valid (db_valid),
        .dn_ready (db_ready),
        .dn_quo   (db_quo),
        .dn_side  (db_side)
    );

    rgbhsv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (db_valid),
        .up_ready (db_ready),
        .up_quo   (db_quo),
        .up_side  (db_side),
        .hsv      (hsv)
    );

endmodule

`default_nettype wire

/* sim/rgb_to_hsv_converter_tb.sv */
`default_nettype none

module rgb_to_hsv_converter_tb;

    localparam int CH_W          = rgbhsv_pkg::CHANNEL_BITS_DEF;
    localparam int FULL_SCALE    = (1 << CH_W) - 1;
    localparam int DRAIN_CYCLES  = 30;
    localparam int STALL_CYCLES  = 150;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int PHASE_ITEMS   = 162;

    typedef struct packed {
        logic [rgbhsv_pkg::HUE_W-1:0] hue;
        logic [rgbhsv_pkg::SAT_W-1:0] sat;
        logic [rgbhsv_pkg::VAL_W-1:0] val;
    } hsv_t;

    typedef struct {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        bit              known;
        hsv_t            want;
    } pixel_case_t;

    logic clk;
    logic rst_n;

    rgbhsv_pixel_if #(.CHANNEL_BITS(CH_W)) pix_if ();
    rgbhsv_hsv_if                          hsv_if ();

    rgb_to_hsv_converter #(
        .CHANNEL_BITS(CH_W)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .pixel(pix_if),
        .hsv  (hsv_if)
    );

    hsv_t pending_hsv[$];
    int   error_count;
    int   result_count;
    int   pixel_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic stall_on;
    event stall_ev;

    // Directed pixels: extremes, primaries, ties, greys, red wrap, bit patterns
    pixel_case_t dir_cases [18] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{12'd0,    10'd0,    10'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{12'd0,    10'd0,    10'd1000}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{12'd0,    10'd1000, 10'd1000}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{12'd1200, 10'd1000, 10'd1000}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{12'd2400, 10'd1000, 10'd1000}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{12'd600,  10'd1000, 10'd1000}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{12'd1800, 10'd1000, 10'd1000}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{12'd3000, 10'd1000, 10'd1000}},
        '{8'd1,   8'd0,   8'd255, 1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'd128, 8'd128, 8'd128, 1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'd1,   8'd1,   8'd1,   1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'd0,   8'd1,   8'd0,   1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'd254, 8'd255, 8'd255, 1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'hAA,  8'h55,  8'hFF,  1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'h55,  8'hAA,  8'h00,  1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'd200, 8'd100, 8'd50,  1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'd10,  8'd250, 8'd250, 1'b0, '{12'd0,    10'd0,    10'd0}},
        '{8'd127, 8'd128, 8'd129, 1'b0, '{12'd0,    10'd0,    10'd0}}
    };

    // Round to nearest, halves up
    function automatic int div_round(input int num, input int den);
        return (2 * num + den) / (2 * den);
    endfunction

    // Compute hue, saturation and value of one pixel
    function automatic hsv_t hsv_of_pixel(input logic [CH_W-1:0] b,
                                          input logic [CH_W-1:0] g,
                                          input logic [CH_W-1:0] r);
        int   bi, gi, ri, top, bottom, span, slope, base, hue;
        hsv_t res;
        bi     = int'(b);
        gi     = int'(g);
        ri     = int'(r);
        top    = ri;
        bottom = ri;
        if (gi > top) top = gi;
        if (bi > top) top = bi;
        if (gi < bottom) bottom = gi;
        if (bi < bottom) bottom = bi;
        span = top - bottom;
        hue  = 0;
        if (span != 0)
        begin
            // pick the sector; red wins ties, then green
            if (ri == top)
            begin
                slope = gi - bi;
                base  = 3600;
            end
            else if (gi == top)
            begin
                slope = bi - ri;
                base  = 1200;
            end
            else
            begin
                slope = ri - gi;
                base  = 2400;
            end
            hue = div_round(600 * slope + base * span, span);
            if (hue >= 3600) hue -= 3600;
        end
        res.hue = hue[rgbhsv_pkg::HUE_W-1:0];
        res.sat = (top == 0) ? '0 : rgbhsv_pkg::SAT_W'(div_round(1000 * span, top));
        res.val = rgbhsv_pkg::VAL_W'(div_round(1000 * top, FULL_SCALE));
        return res;
    endfunction

    // Draw a pixel, weighted toward greys, ties, extremes and narrow spreads
    task automatic pick_pixel(output logic [CH_W-1:0] b,
                              output logic [CH_W-1:0] g,
                              output logic [CH_W-1:0] r);
        logic [CH_W-1:0] lo;
        int              kind;
        kind = $urandom_range(9, 0);
        b    = CH_W'($urandom);
        g    = CH_W'($urandom);
        r    = CH_W'($urandom);
        case (kind)
            5:
            begin
                g = b;
                r = b;
            end
            6:
            begin
                case ($urandom_range(2, 0))
                    0: g = r;
                    1: b = g;
                    default: b = r;
                endcase
            end
            7:
            begin
                case ($urandom_range(2, 0))
                    0: r = $urandom_range(1, 0) ? CH_W'(FULL_SCALE) : '0;
                    1: g = $urandom_range(1, 0) ? CH_W'(FULL_SCALE) : '0;
                    default: b = $urandom_range(1, 0) ? CH_W'(FULL_SCALE) : '0;
                endcase
            end
            8:
            begin
                lo = CH_W'($urandom_range(FULL_SCALE - 3, 0));
                b  = lo + CH_W'($urandom_range(3, 0));
                g  = lo + CH_W'($urandom_range(3, 0));
                r  = lo + CH_W'($urandom_range(3, 0));
            end
            9:
            begin
                b = $urandom_range(1, 0) ? CH_W'(FULL_SCALE) : '0;
                g = $urandom_range(1, 0) ? CH_W'(FULL_SCALE) : '0;
                r = $urandom_range(1, 0) ? CH_W'(FULL_SCALE) : CH_W'($urandom_range(1, 0));
            end
            default: ;
        endcase
    endtask

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Offer one pixel beat after a random gap; queue its result on acceptance
    task automatic send_pixel(input logic [CH_W-1:0] b,
                              input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] r,
                              input hsv_t            want);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.blue  <= b;
        pix_if.green <= g;
        pix_if.red   <= r;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        pending_hsv = {pending_hsv, want};
        pixel_count++;
    endtask

    task automatic send_random(input int count);
        logic [CH_W-1:0] b, g, r;
        repeat (count)
        begin
            pick_pixel(b, g, r);
            send_pixel(b, g, r, hsv_of_pixel(b, g, r));
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hold the receiver off for a long stretch on request
    initial
    begin
        stall_on = 1'b0;
        forever
        begin
            @(stall_ev);
            stall_on <= 1'b1;
            repeat (STALL_CYCLES) @(posedge clk);
            stall_on <= 1'b0;
        end
    end

    // Check each result beat against the oldest pending one, then drive ready
    initial
    begin
        hsv_t got, want;
        hsv_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hsv_if.valid && hsv_if.ready)
            begin
                got = '{hsv_if.hue_tenths, hsv_if.sat_tenths, hsv_if.value_tenths};
                if (pending_hsv.size() == 0)
                begin
                    report_error($sformatf("unexpected result hue=%0d sat=%0d val=%0d",
                                           got.hue, got.sat, got.val));
                end
                else
                begin
                    want = pending_hsv.pop_front();
                    result_count++;
                    if (got.hue !== want.hue)
                        report_error($sformatf("hue_tenths got %0d expected %0d",
                                               got.hue, want.hue));
                    if (got.sat !== want.sat)
                        report_error($sformatf("sat_tenths got %0d expected %0d",
                                               got.sat, want.sat));
                    if (got.val !== want.val)
                        report_error($sformatf("value_tenths got %0d expected %0d",
                                               got.val, want.val));
                end
            end
            if (stall_on)
                hsv_if.ready <= 1'b0;
            else
                hsv_if.ready <= !(recv_idle_pct != 0 &&
                                  $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Drop the run if no beat moves on either side for too long
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((pix_if.valid && pix_if.ready) || (hsv_if.valid && hsv_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_MAX)
            begin
                $display("Timeout: no beat for %0d cycles, %0d results pending",
                         quiet, pending_hsv.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        error_count   = 0;
        result_count  = 0;
        pixel_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        pix_if.valid  <= 1'b0;
        pix_if.blue   <= '0;
        pix_if.green  <= '0;
        pix_if.red    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sender sparse, receiver mostly stalled
        send_idle_pct = 33;
        recv_idle_pct = 84;
        foreach (dir_cases[i])
            send_pixel(dir_cases[i].blue, dir_cases[i].green, dir_cases[i].red,
                       dir_cases[i].known ? dir_cases[i].want
                                          : hsv_of_pixel(dir_cases[i].blue,
                                                         dir_cases[i].green,
                                                         dir_cases[i].red));
        send_random(PHASE_ITEMS);

        // sender mostly idle, receiver eager
        send_idle_pct = 84;
        recv_idle_pct = 33;
        send_random(PHASE_ITEMS);

        // full rate, opening with a long output stall to back up the pipeline
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> stall_ev;
        send_random(PHASE_ITEMS);
        pix_if.valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_hsv.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels (%0d directed), checked %0d results, %0d errors",
                 pixel_count, $size(dir_cases), result_count, error_count);
        $display("Covered three idling mixes and a %0d-cycle output stall at full rate",
                 STALL_CYCLES);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* rgb_to_hsv_converter.f */
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgbhsv_pixel_if.sv
hw/rtl/rgbhsv_hsv_if.sv
hw/rtl/rgbhsv_front.sv
hw/rtl/rgbhsv_div.sv
hw/rtl/rgbhsv_back.sv
hw/rtl/rgb_to_hsv_converter.sv
sim/rgb_to_hsv_converter_tb.sv
